// ----- sv/tac_pkg.sv -----
// Types, codes and sizes shared by the temperature alarm controller.
// No dependencies.
`default_nettype none

package tac_pkg;

  localparam int MAX_DIGITS_DEFAULT = 3;
  localparam int CNT_W              = 2;
  localparam int DIGIT_W            = 4;

  localparam logic [7:0] BLINK_TICKS_RESET = 8'd10;

  // Keypad codes
  localparam logic [7:0] KEY_ONE    = 8'd1;
  localparam logic [7:0] KEY_ZERO   = 8'd10;
  localparam logic [7:0] KEY_CANCEL = 8'd12;
  localparam logic [7:0] KEY_ARM    = 8'd13;
  localparam logic [7:0] KEY_ENTRY  = 8'd15;

  // Serial bytes
  localparam logic [7:0] CHAR_GO      = 8'h47;  // 'G'
  localparam logic [7:0] CHAR_CANCEL  = 8'h43;  // 'C'
  localparam logic [7:0] CHAR_OK      = 8'h4F;  // 'O'
  localparam logic [7:0] CHAR_SILENCE = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_0       = 8'h30;  // '0'
  localparam logic [7:0] CHAR_9       = 8'h39;  // '9'

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_KEY    = 2'd1,
    OP_SERIAL = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_MONITOR = 2'd0,
    MODE_KEYPAD  = 2'd1,
    MODE_SERIAL  = 2'd2,
    MODE_ALARM   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] event_value;
  } event_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               alarm_enabled;
    logic [7:0]         threshold;
    logic [7:0]         current_temp;
    logic               buzzer_on;
    logic               echo_valid;
    logic [DIGIT_W-1:0] echo_digit;
    logic [1:0]         echo_slot;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/temperature_alarm_controller_unit.sv -----
// Temperature alarm controller: mode sequencing, threshold entry and buzzer blink.
// Depends on tac_pkg for event/status structs, modes and key/byte codes.
`default_nettype none

//  channel  | direction | handshake             | beat
//  ---------+-----------+-----------------------+------------------------------
//  in       | in        | in_valid / in_stall   | event_t: opcode, event_value
//  out      | out       | out_valid / out_stall | status_t: one per input event
//  cfg      | in        | cfg_valid / cfg_ready | blink_ticks (8 bit)
//
// One event per cycle while in_stall is low: the event and the held state feed
// one pass of decode logic, the state registers update at acceptance and the
// status beat lands in the output register on the same edge.
// in_stall rises only while the output register holds a beat that is stalled;
// a beat leaving in the same cycle frees the slot for the next event.
// Synchronous reset clears mode, flags, threshold, counters and blink_ticks (10).
// cfg_ready is always high; write blink_ticks only while the block is idle.

module temperature_alarm_controller_unit
  import tac_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT  // 1..3
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire event_t   in_item,
  output      logic     out_valid,
  input  wire logic     out_stall,
  output      status_t  out_item,
  input  wire logic     cfg_valid,
  output      logic     cfg_ready,
  input  wire logic [7:0] cfg_data
);

  // Architectural state
  logic [7:0]         blink_ticks;
  mode_t              mode_reg;
  logic               armed;
  logic [7:0]         limit;
  logic [7:0]         temp_reg;
  logic [CNT_W-1:0]   digit_count;
  logic [7:0]         blink_count;
  logic               drive_level;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];

  // Next values
  mode_t              mode_next;
  logic               armed_next;
  logic [7:0]         limit_next;
  logic [7:0]         temp_next;
  logic [CNT_W-1:0]   count_next;
  logic [7:0]         blink_next;
  logic               drive_next;
  logic               take_digit;
  logic [DIGIT_W-1:0] digit_val;
  logic [7:0]         folded;
  status_t            result;

  logic accept;

  // The output register is the only place a beat can wait.
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Fold the entered digits into a threshold, decimal, modulo 256.
  always_comb begin
    folded = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < digit_count) begin
        folded = {folded[4:0], 3'b000} + {folded[6:0], 1'b0}
               + {{(8-DIGIT_W){1'b0}}, digits[i]};
      end
    end
  end

  // Next-state logic for one event.
  always_comb begin
    logic [7:0] v;
    logic [7:0] v_ascii;
    logic       do_check;
    logic       room;

    v          = in_item.event_value;
    v_ascii    = v - CHAR_0;
    do_check   = 1'b0;
    room       = digit_count < CNT_W'(MAX_DIGITS);

    mode_next  = mode_reg;
    armed_next = armed;
    limit_next = limit;
    temp_next  = (in_item.opcode == OP_SAMPLE) ? v : temp_reg;
    count_next = digit_count;
    blink_next = blink_count;
    drive_next = drive_level;
    take_digit = 1'b0;
    digit_val  = '0;

    unique case (mode_reg)
      MODE_MONITOR: begin
        if (in_item.opcode == OP_SAMPLE) begin
          do_check = 1'b1;
        end else if (in_item.opcode == OP_KEY) begin
          if (v == KEY_ENTRY) begin
            mode_next  = MODE_KEYPAD;
            count_next = '0;
          end else if (v == KEY_ARM) begin
            armed_next = ~armed;
            do_check   = 1'b1;
          end
        end else if (in_item.opcode == OP_SERIAL && v == CHAR_GO) begin
          mode_next  = MODE_SERIAL;
          count_next = '0;
        end
      end
      MODE_KEYPAD: begin
        if (in_item.opcode == OP_KEY) begin
          if (v == KEY_CANCEL) begin
            mode_next = MODE_MONITOR;
            do_check  = 1'b1;
          end else if (v == KEY_ENTRY) begin
            limit_next = folded;
            mode_next  = MODE_MONITOR;
            do_check   = 1'b1;
          end else if (v >= KEY_ONE && v <= KEY_ZERO && room) begin
            take_digit = 1'b1;
            digit_val  = (v == KEY_ZERO) ? '0 : v[DIGIT_W-1:0];
          end
        end
      end
      MODE_SERIAL: begin
        if (in_item.opcode == OP_SERIAL) begin
          if (v == CHAR_CANCEL) begin
            mode_next = MODE_MONITOR;
            do_check  = 1'b1;
          end else if (v == CHAR_OK) begin
            limit_next = folded;
            mode_next  = MODE_MONITOR;
            do_check   = 1'b1;
          end else if (v >= CHAR_0 && v <= CHAR_9 && room) begin
            take_digit = 1'b1;
            digit_val  = v_ascii[DIGIT_W-1:0];
          end
        end
      end
      MODE_ALARM: begin
        if (in_item.opcode == OP_TICK) begin
          // Toggle once the count reaches blink_ticks, then advance and saturate.
          if (blink_count >= blink_ticks) begin
            drive_next = ~drive_level;
            blink_next = 8'd1;
          end else if (blink_count != 8'hFF) begin
            blink_next = blink_count + 8'd1;
          end
        end else if (in_item.opcode == OP_SAMPLE) begin
          if (v < limit) begin
            mode_next  = MODE_MONITOR;
            blink_next = '0;
            drive_next = 1'b0;
          end
        end else if ((in_item.opcode == OP_KEY && v == KEY_CANCEL) ||
                     (in_item.opcode == OP_SERIAL && v == CHAR_SILENCE)) begin
          // Silence: drop the alarm and disarm.
          armed_next = 1'b0;
          mode_next  = MODE_MONITOR;
          blink_next = '0;
          drive_next = 1'b0;
        end
      end
      default: begin
        mode_next = mode_reg;
      end
    endcase

    if (take_digit) begin
      count_next = digit_count + CNT_W'(1);
    end

    // Alarm check against the updated flag, sample and threshold.
    if (do_check && armed_next && temp_next >= limit_next) begin
      mode_next  = MODE_ALARM;
      blink_next = '0;
      drive_next = 1'b0;
    end
  end

  // Status beat for this event.
  always_comb begin
    result.mode          = mode_next;
    result.alarm_enabled = armed_next;
    result.threshold     = limit_next;
    result.current_temp  = temp_next;
    result.buzzer_on     = drive_next;
    result.echo_valid    = take_digit;
    result.echo_digit    = take_digit ? digit_val : '0;
    result.echo_slot     = take_digit ? digit_count : '0;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_ticks <= BLINK_TICKS_RESET;
      mode_reg    <= MODE_MONITOR;
      armed       <= 1'b0;
      limit       <= '0;
      temp_reg    <= '0;
      digit_count <= '0;
      blink_count <= '0;
      drive_level <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        blink_ticks <= cfg_data;
      end
      if (accept) begin
        mode_reg    <= mode_next;
        armed       <= armed_next;
        limit       <= limit_next;
        temp_reg    <= temp_next;
        digit_count <= count_next;
        blink_count <= blink_next;
        drive_level <= drive_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Digit store and output payload: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (take_digit && digit_count == CNT_W'(i)) begin
          digits[i] <= digit_val;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for temperature_alarm_controller_unit.
// Holds a status predictor and scoreboard class and drives randomized event beats.
// Depends on tac_pkg and the controller RTL.
`timescale 1ns / 100ps

module tb;
  import tac_pkg::*;

  localparam int WATCHDOG_LIMIT = 200;  // cycles with no beat moving on any channel

  // Predictor of the controller plus the queue of status beats it still owes.
  class status_board;
    logic [7:0] blink_ticks;
    mode_t      mode;
    bit         armed;
    logic [7:0] limit;
    logic [7:0] temp;
    logic [3:0] digits [3];
    int         count;
    logic [7:0] blink_cnt;
    bit         level;
    status_t    awaited_status [$];
    int         errors;

    function new();
      blink_ticks = BLINK_TICKS_RESET;
      mode        = MODE_MONITOR;
      armed       = 1'b0;
      limit       = '0;
      temp        = '0;
      count       = 0;
      blink_cnt   = '0;
      level       = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return awaited_status.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("tb: status mismatch, %s", msg);
    endtask

    function void raise_if_hot();
      if (armed && temp >= limit) begin
        mode      = MODE_ALARM;
        blink_cnt = '0;
        level     = 1'b0;
      end
    endfunction

    function void close_entry(bit commit);
      logic [7:0] t;
      t = '0;
      if (commit) begin
        for (int i = 0; i < count; i++) t = 8'(t * 10 + digits[i]);
        limit = t;
      end
      mode = MODE_MONITOR;
      raise_if_hot();
    endfunction

    function void quiet();
      mode      = MODE_MONITOR;
      level     = 1'b0;
      blink_cnt = '0;
    endfunction

    function status_t next_status(event_t ev);
      op_t        op;
      logic [7:0] v;
      logic [3:0] d;
      bit         is_digit;
      status_t    s;
      op       = op_t'(ev.opcode);
      v        = ev.event_value;
      d        = '0;
      is_digit = 1'b0;
      s        = '0;
      if (op == OP_SAMPLE) temp = v;
      case (mode)
        MODE_MONITOR: begin
          if (op == OP_SAMPLE) begin
            raise_if_hot();
          end else if (op == OP_KEY && v == KEY_ENTRY) begin
            mode  = MODE_KEYPAD;
            count = 0;
          end else if (op == OP_KEY && v == KEY_ARM) begin
            armed = !armed;
            raise_if_hot();
          end else if (op == OP_SERIAL && v == CHAR_GO) begin
            mode  = MODE_SERIAL;
            count = 0;
          end
        end
        MODE_KEYPAD: begin
          if (op == OP_KEY) begin
            if (v == KEY_CANCEL) begin
              close_entry(1'b0);
            end else if (v == KEY_ENTRY) begin
              close_entry(1'b1);
            end else if (v >= KEY_ONE && v <= KEY_ZERO) begin
              is_digit = 1'b1;
              d        = (v == KEY_ZERO) ? 4'd0 : v[3:0];
            end
          end
        end
        MODE_SERIAL: begin
          if (op == OP_SERIAL) begin
            if (v == CHAR_CANCEL) begin
              close_entry(1'b0);
            end else if (v == CHAR_OK) begin
              close_entry(1'b1);
            end else if (v >= CHAR_0 && v <= CHAR_9) begin
              is_digit = 1'b1;
              d        = 4'(v - CHAR_0);
            end
          end
        end
        MODE_ALARM: begin
          if (op == OP_TICK) begin
            if (blink_cnt >= blink_ticks) begin
              blink_cnt = '0;
              level     = !level;
            end
            if (blink_cnt != 8'hFF) blink_cnt++;
          end else if (op == OP_SAMPLE) begin
            if (temp < limit) quiet();
          end else if (op == OP_KEY) begin
            if (v == KEY_CANCEL) begin
              armed = 1'b0;
              quiet();
            end
          end else if (v == CHAR_SILENCE) begin
            armed = 1'b0;
            quiet();
          end
        end
      endcase
      // Drop digits once the entry buffer is full.
      if (is_digit && count < MAX_DIGITS_DEFAULT) begin
        digits[count] = d;
        s.echo_valid  = 1'b1;
        s.echo_digit  = d;
        s.echo_slot   = 2'(count);
        count++;
      end
      s.mode          = mode;
      s.alarm_enabled = armed;
      s.threshold     = limit;
      s.current_temp  = temp;
      s.buzzer_on     = level;
      return s;
    endfunction

    function void note_event(event_t ev);
      awaited_status.push_back(next_status(ev));
    endfunction

    task check_status(status_t got);
      status_t want;
      if (awaited_status.size() == 0) begin
        report("status beat with nothing awaited");
        return;
      end
      want = awaited_status.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("mode got %0d want %0d", got.mode, want.mode));
      if (got.alarm_enabled !== want.alarm_enabled)
        report($sformatf("alarm_enabled got %0d want %0d", got.alarm_enabled,
                         want.alarm_enabled));
      if (got.threshold !== want.threshold)
        report($sformatf("threshold got %0d want %0d", got.threshold, want.threshold));
      if (got.current_temp !== want.current_temp)
        report($sformatf("current_temp got %0d want %0d", got.current_temp,
                         want.current_temp));
      if (got.buzzer_on !== want.buzzer_on)
        report($sformatf("buzzer_on got %0d want %0d", got.buzzer_on, want.buzzer_on));
      if (got.echo_valid !== want.echo_valid)
        report($sformatf("echo_valid got %0d want %0d", got.echo_valid, want.echo_valid));
      if (got.echo_digit !== want.echo_digit)
        report($sformatf("echo_digit got %0d want %0d", got.echo_digit, want.echo_digit));
      if (got.echo_slot !== want.echo_slot)
        report($sformatf("echo_slot got %0d want %0d", got.echo_slot, want.echo_slot));
    endtask
  endclass

  // Every block input starts at a known value.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  event_t     in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  status_t    out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  status_board board;
  int          sent     = 0;
  int          in_calm  = 0;  // beats left in a no-gap stretch on the event side
  int          out_calm = 0;  // same for the status side
  int          idle_run = 0;

  temperature_alarm_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Draw the wait before the next beat, with occasional
  // stretches where the side never idles.
  function automatic int idle_cycles(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Offer one event beat and hold it until the block takes it. Valid stays
  // high across back-to-back beats; only the payload changes.
  task automatic send_event(op_t op, logic [7:0] v);
    event_t ev;
    int     gap;
    ev.opcode      = op;
    ev.event_value = v;
    gap            = idle_cycles(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_event(ev);
    sent++;
  endtask

  task automatic send_noise();
    send_event(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Write blink_ticks only once every status beat is back, plus a little slack.
  task automatic write_blink(logic [7:0] ticks);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid         <= 1'b0;
    board.blink_ticks  = ticks;
  endtask

  task automatic keypad_entry();
    send_event(OP_KEY, KEY_ENTRY);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_event(OP_KEY, 8'($urandom_range(1, 10)));
    end
    if ($urandom_range(0, 3) == 0) send_event(OP_KEY, KEY_CANCEL);
    else send_event(OP_KEY, KEY_ENTRY);
  endtask

  task automatic serial_entry();
    send_event(OP_SERIAL, CHAR_GO);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_event(OP_SERIAL, 8'(CHAR_0 + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) == 0) send_event(OP_SERIAL, CHAR_CANCEL);
    else send_event(OP_SERIAL, CHAR_OK);
  endtask

  // Push a sample, arm if needed, blink for a while, then leave the alarm.
  // Now and then run enough ticks to pass blink_ticks even at its top.
  task automatic alarm_episode();
    int ticks;
    send_event(OP_SAMPLE, 8'($urandom_range(0, 255)));
    if (!board.armed) send_event(OP_KEY, KEY_ARM);
    ticks = ($urandom_range(0, 7) == 0) ? int'(board.blink_ticks) + 2
                                        : $urandom_range(1, 12);
    repeat (ticks) send_event(OP_TICK, 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 2))
      0:       send_event(OP_SAMPLE, 8'($urandom_range(0, 255)));
      1:       send_event(OP_KEY, KEY_CANCEL);
      default: send_event(OP_SERIAL, CHAR_SILENCE);
    endcase
  endtask

  task automatic random_phase(int budget);
    int start;
    start = sent;
    while (sent - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2: keypad_entry();
        3, 4, 5: serial_entry();
        6, 7, 8: alarm_episode();
        default: send_noise();
      endcase
    end
  endtask

  // Status side: stall at random, take each beat and check it.
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = idle_cycles(out_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      board.check_status(out_item);
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at the reset blink rate.
    send_event(OP_SAMPLE, 8'd0);          // monitor, disarmed: no alarm
    send_event(OP_KEY, KEY_ARM);          // arm with temp 0 >= threshold 0: alarm
    send_event(OP_TICK, 8'd255);          // blink counter advances
    send_event(OP_SERIAL, CHAR_SILENCE);  // silence by serial, disarm
    send_event(OP_KEY, KEY_ENTRY);
    send_event(OP_KEY, KEY_ONE);
    send_event(OP_KEY, KEY_ZERO);         // key code for digit zero
    send_event(OP_KEY, 8'd9);
    send_event(OP_KEY, 8'd5);             // buffer full: dropped
    send_event(OP_KEY, KEY_ENTRY);        // confirm: threshold 109
    send_event(OP_SERIAL, CHAR_GO);
    send_event(OP_SERIAL, CHAR_9);
    send_event(OP_SERIAL, CHAR_9);
    send_event(OP_SAMPLE, 8'd255);        // stored during entry, not checked
    send_event(OP_SERIAL, CHAR_9);
    send_event(OP_SERIAL, CHAR_OK);       // 999 wraps to 231
    send_event(OP_KEY, KEY_ENTRY);
    send_event(OP_KEY, KEY_CANCEL);       // cancel keeps the threshold
    send_event(OP_SERIAL, CHAR_GO);
    send_event(OP_SERIAL, CHAR_CANCEL);
    send_event(OP_KEY, KEY_ARM);          // 255 >= 231: alarm
    send_event(OP_SAMPLE, 8'd0);          // below threshold: back to monitor
    send_event(OP_SAMPLE, 8'd255);        // alarm again
    send_event(OP_KEY, KEY_CANCEL);       // silence by keypad
    send_event(OP_TICK, 8'd0);            // tick outside alarm: ignored
    send_event(OP_KEY, 8'd0);
    send_event(OP_SERIAL, 8'd255);

    // Random phases across blink rates, extremes included.
    write_blink(8'd1);
    random_phase(180);
    write_blink(8'd0);
    random_phase(140);
    write_blink(8'd255);
    random_phase(160);
    write_blink(8'($urandom_range(2, 20)));
    random_phase(180);

    // Drain and let the pipeline settle before the verdict.
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
